// File: rtl/core/sboc_pkg.sv
// Shared types, codes and helpers for the select-before-operate control core.
// No dependencies; every module of the core imports this package.
`timescale 1ns / 1ps

package sboc_pkg;

    localparam logic [7:0] NUM_MAX = 8'd255;

    // command codes
    localparam logic [2:0] CMD_SELECT     = 3'd0;
    localparam logic [2:0] CMD_SELECT_VAL = 3'd1;
    localparam logic [2:0] CMD_OPERATE    = 3'd2;
    localparam logic [2:0] CMD_CANCEL     = 3'd3;
    localparam logic [2:0] CMD_TERM       = 3'd4;
    localparam logic [2:0] CMD_ASSOC_CLR  = 3'd5;
    localparam logic [2:0] CMD_TICK       = 3'd6;

    // control models
    localparam logic [2:0] MODEL_STATUS_ONLY = 3'd0;
    localparam logic [2:0] MODEL_DIRECT_NORM = 3'd1;
    localparam logic [2:0] MODEL_SBO_NORM    = 3'd2;
    localparam logic [2:0] MODEL_DIRECT_ENH  = 3'd3;
    localparam logic [2:0] MODEL_SBO_ENH     = 3'd4;

    // register indexes
    localparam logic [1:0] REG_CONTROL_MODEL = 2'd0;
    localparam logic [1:0] REG_SBO_TIMEOUT   = 2'd1;
    localparam logic [1:0] REG_OBJECT_OK     = 2'd2;

    // actions
    localparam logic [1:0] ACT_SELECT     = 2'd0;
    localparam logic [1:0] ACT_SELECT_VAL = 2'd1;
    localparam logic [1:0] ACT_OPERATE    = 2'd2;
    localparam logic [1:0] ACT_CANCEL     = 2'd3;

    // status codes
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_UNSUP    = 4'd1;
    localparam logic [3:0] ST_IDENT    = 4'd2;
    localparam logic [3:0] ST_SEQ      = 4'd3;
    localparam logic [3:0] ST_EXEC     = 4'd4;
    localparam logic [3:0] ST_ALREADY  = 4'd5;
    localparam logic [3:0] ST_LOCKED   = 4'd6;
    localparam logic [3:0] ST_DENIED   = 4'd7;
    localparam logic [3:0] ST_EXPIRED  = 4'd8;
    localparam logic [3:0] ST_NOTSEL   = 4'd9;
    localparam logic [3:0] ST_MISMATCH = 4'd10;
    localparam logic [3:0] ST_WAITING  = 4'd11;
    localparam logic [3:0] ST_NOSEL    = 4'd12;
    localparam logic [3:0] ST_NOPEND   = 4'd13;
    localparam logic [3:0] ST_POS      = 4'd14;
    localparam logic [3:0] ST_NEG      = 4'd15;

    // add-cause codes
    localparam logic [4:0] AC_UNKNOWN = 5'd0;
    localparam logic [4:0] AC_NOTSUP  = 5'd1;
    localparam logic [4:0] AC_INEXEC  = 5'd12;
    localparam logic [4:0] AC_CANCEL  = 5'd15;
    localparam logic [4:0] AC_TIMEOUT = 5'd16;
    localparam logic [4:0] AC_NOTSEL  = 5'd18;
    localparam logic [4:0] AC_ALREADY = 5'd19;
    localparam logic [4:0] AC_NOAUTH  = 5'd20;
    localparam logic [4:0] AC_NONE    = 5'd25;
    localparam logic [4:0] AC_INCONS  = 5'd26;
    localparam logic [4:0] AC_LOCKED  = 5'd27;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [31:0] data;
    } t_cfg_wr;

    // classified command as it travels from front to back
    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] now;
        logic [63:0] client;
        logic        client_nz;
        logic        cok;
        logic        sok;
        logic        auth;
        logic [7:0]  req;
        logic [63:0] digest;
        logic [1:0]  terr;
        logic [4:0]  tcause;
        logic [63:0] sel_expiry;
        logic        model_match;
        logic        sbo;
        logic        enh;
        logic        op_unsup;
    } t_item;

    typedef struct packed {
        logic        sel;
        logic        waiting;
        logic [63:0] owner;
        logic [63:0] expiry;
        logic [63:0] digest;
        logic [7:0]  act_num;
        logic [7:0]  next_num;
    } t_state;

    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  action;
        logic [7:0]  number;
        logic [1:0]  err;
        logic [4:0]  cause;
        logic        selected;
        logic        waiting;
        logic [63:0] owner;
        logic [63:0] expiry;
    } t_result;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } t_back_state;

    // drops the selection and pending execution; the allocator survives
    function automatic t_state clear_state(input t_state s);
        t_state c;
        c         = s;
        c.sel     = 1'b0;
        c.waiting = 1'b0;
        c.owner   = '0;
        c.expiry  = '0;
        c.digest  = '0;
        c.act_num = '0;
        return c;
    endfunction

endpackage

// File: rtl/core/select_before_operate_control_core.sv
// Select-before-operate control core: one decision beat per command beat.
// Commands go from the queue to the item register, then are decided and committed to the output
// register; an output stall holds the commit. The back end takes no new command until that
// commit, as its compare/commit pair works on the single control-object state; the front queue absorbs bursts.
// Reset (synchronous, active low) clears configuration, state, queue and output valid.
`timescale 1ns / 1ps

module select_before_operate_control_core import sboc_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [63:0] i_now_ms,
    input  logic [63:0] i_client_id,
    input  logic        i_client_ok,
    input  logic        i_sequence_ok,
    input  logic        i_authorized,
    input  logic [7:0]  i_requested_number,
    input  logic [63:0] i_sequence_digest,
    input  logic [1:0]  i_term_error,
    input  logic [4:0]  i_term_cause,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_status,
    output logic [1:0]  o_action,
    output logic [7:0]  o_ctl_number,
    output logic [1:0]  o_error_code,
    output logic [4:0]  o_cause_code,
    output logic        o_is_selected,
    output logic        o_is_waiting,
    output logic [63:0] o_owner_id,
    output logic [63:0] o_expires_at
);

    t_cfg_wr cfg;
    t_item   f_item, q_head;
    logic    q_full, q_valid, push, pop;
    t_result res;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    sboc_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_valid            (i_in_valid),
        .i_cmd              (i_cmd),
        .i_now_ms           (i_now_ms),
        .i_client_id        (i_client_id),
        .i_client_ok        (i_client_ok),
        .i_sequence_ok      (i_sequence_ok),
        .i_authorized       (i_authorized),
        .i_requested_number (i_requested_number),
        .i_sequence_digest  (i_sequence_digest),
        .i_term_error       (i_term_error),
        .i_term_cause       (i_term_cause),
        .i_q_full           (q_full),
        .o_stall            (o_in_stall),
        .o_push             (push),
        .o_item             (f_item)
    );

    sboc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    sboc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (res)
    );

    assign o_status      = res.status;
    assign o_action      = res.action;
    assign o_ctl_number  = res.number;
    assign o_error_code  = res.err;
    assign o_cause_code  = res.cause;
    assign o_is_selected = res.selected;
    assign o_is_waiting  = res.waiting;
    assign o_owner_id    = res.owner;
    assign o_expires_at  = res.expiry;

endmodule

// File: rtl/core/sboc_front.sv
// Front end: configuration registers, input beat acceptance and classification.
// Depends on sboc_pkg; feeds sboc_queue.
`timescale 1ns / 1ps

module sboc_front import sboc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg_wr     i_cfg,
    input  logic        i_valid,
    input  logic [2:0]  i_cmd,
    input  logic [63:0] i_now_ms,
    input  logic [63:0] i_client_id,
    input  logic        i_client_ok,
    input  logic        i_sequence_ok,
    input  logic        i_authorized,
    input  logic [7:0]  i_requested_number,
    input  logic [63:0] i_sequence_digest,
    input  logic [1:0]  i_term_error,
    input  logic [4:0]  i_term_cause,
    input  logic        i_q_full,
    output logic        o_stall,
    output logic        o_push,
    output t_item       o_item
);

    logic [2:0]  r_model;
    logic [31:0] r_timeout;
    logic        r_object_ok;
    logic [64:0] sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model     <= MODEL_STATUS_ONLY;
            r_timeout   <= '0;
            r_object_ok <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_CONTROL_MODEL: r_model     <= i_cfg.data[2:0];
                REG_SBO_TIMEOUT:   r_timeout   <= i_cfg.data;
                REG_OBJECT_OK:     r_object_ok <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // carry out of the add means the expiry saturates
    assign sum = {1'b0, i_now_ms} + {33'b0, r_timeout};

    always_comb begin
        o_item.cmd         = i_cmd;
        o_item.now         = i_now_ms;
        o_item.client      = i_client_id;
        o_item.client_nz   = |i_client_id;
        o_item.cok         = i_client_ok;
        o_item.sok         = i_sequence_ok;
        o_item.auth        = i_authorized;
        o_item.req         = i_requested_number;
        o_item.digest      = i_sequence_digest;
        o_item.terr        = i_term_error;
        o_item.tcause      = i_term_cause;
        o_item.sel_expiry  = (r_timeout == '0) ? '0 : (sum[64] ? '1 : sum[63:0]);
        o_item.model_match = (i_cmd == CMD_SELECT && r_model == MODEL_SBO_NORM)
                          || (i_cmd == CMD_SELECT_VAL && r_model == MODEL_SBO_ENH);
        o_item.sbo         = (r_model == MODEL_SBO_NORM) || (r_model == MODEL_SBO_ENH);
        o_item.enh         = (r_model == MODEL_DIRECT_ENH) || (r_model == MODEL_SBO_ENH);
        o_item.op_unsup    = !r_object_ok || (r_model == MODEL_STATUS_ONLY)
                          || (r_model > MODEL_SBO_ENH);
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

// File: rtl/core/sboc_queue.sv
// Small FIFO of classified commands between the front and back ends.
// Depends on sboc_pkg for the entry type.
`timescale 1ns / 1ps

module sboc_queue import sboc_pkg::*; #(
    parameter int unsigned DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_item        r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wr, n_rd;
    logic [CW-1:0] n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// File: rtl/core/sboc_back.sv
// Back end: control-object state, decision sequencer and output register.
// Depends on sboc_pkg; consumes entries from sboc_queue.
`timescale 1ns / 1ps

module sboc_back import sboc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_item   i_q_head,
    output logic    o_pop,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_result o_result
);

    t_back_state r_bk, n_bk;
    t_state      r_st, n_st;
    t_item       r_item;
    logic        r_due, r_own_eq, r_dig_eq;
    logic        r_out_valid, n_out_valid;
    t_result     r_out, d;
    logic        commit;
    logic [7:0]  take_num;

    assign o_pop  = (r_bk == BK_IDLE) && i_q_valid;
    assign commit = (r_bk == BK_EXEC) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bk        <= BK_IDLE;
            r_st        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_bk        <= n_bk;
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
        end
    end

    // pop step: wide compares against the state, which holds still until commit
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item   <= i_q_head;
            r_due    <= r_st.sel && (r_st.expiry != '0) && (i_q_head.now >= r_st.expiry);
            r_own_eq <= (r_st.owner == i_q_head.client);
            r_dig_eq <= (r_st.digest == i_q_head.digest);
        end
        if (commit) begin
            r_out <= d;
        end
    end

    always_comb begin
        n_bk        = r_bk;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_bk)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_bk = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (commit) begin
                    n_bk        = BK_IDLE;
                    n_out_valid = 1'b1;
                end
            end
        endcase
    end

    assign take_num = (r_item.req != '0) ? r_item.req
                    : ((r_st.next_num >= NUM_MAX) ? 8'd1 : r_st.next_num + 8'd1);

    // commit step: decision and state update
    always_comb begin
        n_st     = r_st;
        d        = '0;
        d.status = ST_OK;
        d.action = ACT_SELECT;
        d.number = r_st.act_num;
        d.err    = 2'd0;
        d.cause  = AC_UNKNOWN;
        unique case (r_item.cmd)
            CMD_SELECT, CMD_SELECT_VAL: begin
                d.action = (r_item.cmd == CMD_SELECT_VAL) ? ACT_SELECT_VAL : ACT_SELECT;
                priority if (!r_item.model_match) begin
                    d.status = ST_UNSUP;
                    d.cause  = AC_NOTSUP;
                end else if (!r_item.cok) begin
                    d.status = ST_IDENT;
                    d.cause  = AC_NOAUTH;
                end else if (!r_item.sok) begin
                    d.status = ST_SEQ;
                    d.cause  = AC_INCONS;
                end else begin
                    if (r_due) begin
                        n_st = clear_state(r_st);
                    end
                    d.number = n_st.act_num;
                    priority if (n_st.waiting) begin
                        d.status = ST_EXEC;
                        d.cause  = AC_INEXEC;
                    end else if (n_st.sel) begin
                        d.status = r_own_eq ? ST_ALREADY : ST_LOCKED;
                        d.cause  = r_own_eq ? AC_ALREADY : AC_LOCKED;
                    end else if (!r_item.auth) begin
                        d.status = ST_DENIED;
                        d.cause  = AC_NOAUTH;
                    end else begin
                        if (r_item.req == '0) begin
                            n_st.next_num = take_num;
                        end
                        n_st.act_num = take_num;
                        n_st.digest  = r_item.digest;
                        n_st.owner   = r_item.client;
                        n_st.expiry  = r_item.sel_expiry;
                        n_st.sel     = 1'b1;
                        d.number     = take_num;
                        d.cause      = AC_NONE;
                    end
                end
            end
            CMD_OPERATE: begin
                d.action = ACT_OPERATE;
                priority if (r_item.op_unsup) begin
                    d.status = ST_UNSUP;
                    d.cause  = AC_NOTSUP;
                end else if (!r_item.cok) begin
                    d.status = ST_IDENT;
                    d.cause  = AC_NOAUTH;
                end else if (!r_item.sok) begin
                    d.status = ST_SEQ;
                    d.cause  = AC_INCONS;
                end else if (r_st.waiting) begin
                    d.status = ST_EXEC;
                    d.cause  = AC_INEXEC;
                end else if (r_item.sbo && r_due) begin
                    n_st     = clear_state(r_st);
                    d.status = ST_EXPIRED;
                    d.cause  = AC_TIMEOUT;
                end else if (r_item.sbo && !r_st.sel) begin
                    d.status = ST_NOTSEL;
                    d.cause  = AC_NOTSEL;
                end else if (r_item.sbo && !r_own_eq) begin
                    d.status = ST_LOCKED;
                    d.cause  = AC_LOCKED;
                end else if (r_item.sbo && (!r_dig_eq ||
                             (r_item.req != '0 && r_item.req != r_st.act_num))) begin
                    n_st     = clear_state(r_st);
                    d.status = ST_MISMATCH;
                    d.cause  = AC_INCONS;
                end else if (!r_item.auth) begin
                    if (r_item.sbo) begin
                        n_st = clear_state(r_st);
                    end
                    d.status = ST_DENIED;
                    d.cause  = AC_NOAUTH;
                end else begin
                    if (r_item.sbo) begin
                        n_st.sel    = 1'b0;
                        n_st.expiry = '0;
                    end else begin
                        if (r_item.req == '0) begin
                            n_st.next_num = take_num;
                        end
                        n_st.act_num = take_num;
                        n_st.digest  = r_item.digest;
                        n_st.owner   = r_item.client;
                        d.number     = take_num;
                    end
                    d.cause = AC_NONE;
                    if (r_item.enh) begin
                        n_st.waiting = 1'b1;
                        d.status     = ST_WAITING;
                    end else begin
                        n_st     = clear_state(n_st);
                        d.status = ST_OK;
                    end
                end
            end
            CMD_CANCEL: begin
                d.action = ACT_CANCEL;
                priority if (!r_item.sbo) begin
                    d.status = ST_UNSUP;
                    d.cause  = AC_NOTSUP;
                end else if (!r_item.cok) begin
                    d.status = ST_IDENT;
                    d.cause  = AC_NOAUTH;
                end else if (r_due) begin
                    n_st     = clear_state(r_st);
                    d.status = ST_EXPIRED;
                    d.cause  = AC_TIMEOUT;
                end else if (!r_st.sel) begin
                    d.status = ST_NOSEL;
                    d.cause  = AC_NOTSEL;
                end else if (!r_own_eq) begin
                    d.status = ST_LOCKED;
                    d.cause  = AC_LOCKED;
                end else if (!r_item.auth) begin
                    d.status = ST_DENIED;
                    d.cause  = AC_NOAUTH;
                end else begin
                    n_st     = clear_state(r_st);
                    d.status = ST_OK;
                    d.cause  = AC_CANCEL;
                end
            end
            CMD_TERM: begin
                d.action = ACT_OPERATE;
                if (!r_st.waiting) begin
                    d.status = ST_NOPEND;
                end else begin
                    d.status = (r_item.terr == 2'd0 && (r_item.tcause == AC_UNKNOWN
                               || r_item.tcause == AC_NONE)) ? ST_POS : ST_NEG;
                    d.err    = r_item.terr;
                    d.cause  = r_item.tcause;
                    n_st     = clear_state(r_st);
                end
            end
            CMD_ASSOC_CLR: begin
                if (r_item.client_nz && r_own_eq) begin
                    n_st = clear_state(r_st);
                end
                d.number = n_st.act_num;
            end
            default: begin
                // tick/query, and the unused code behaves the same
                if (r_due) begin
                    n_st = clear_state(r_st);
                end
                d.number = n_st.act_num;
            end
        endcase
        d.selected = n_st.sel;
        d.waiting  = n_st.waiting;
        d.owner    = n_st.owner;
        d.expiry   = n_st.expiry;
        if (!commit) begin
            n_st = r_st;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule
